// ===== rtl/core/fdhp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdhp_pkg
// Shared constants, codes and control types of the fence-deferred handle pool.
// ----------------------------------------------------------------------------
package fdhp_pkg;

	localparam int MAX_HANDLES = 16;
	localparam int IDX_W       = $clog2(MAX_HANDLES);
	localparam int CNT_W       = IDX_W + 1;
	localparam int HANDLE_W    = 4;
	localparam int FENCE_W     = 64;
	localparam int LIMIT_W     = 5;
	localparam int FREED_W     = 5;
	localparam int OP_W        = 2;
	localparam int STATUS_W    = 2;
	localparam int CMP_W       = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;
	localparam int DEF_W       = HANDLE_W + FENCE_W;
	localparam int APB_AW      = 3;
	localparam int APB_DW      = 32;

	localparam logic [OP_W-1:0] OP_ACQUIRE = 2'd0;
	localparam logic [OP_W-1:0] OP_RELEASE = 2'd1;
	localparam logic [OP_W-1:0] OP_PROCESS = 2'd2;

	localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_EXHAUSTED = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_DEF_FULL  = 2'd2;
	localparam logic [STATUS_W-1:0] STAT_NULL_REL  = 2'd3;

	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd16;
	localparam logic [FREED_W-1:0] FREED_MAX   = 5'd31;
	localparam logic               REG_HANDLE_LIMIT = 1'b0;

	typedef enum logic [1:0] {
		FSM_IDLE,
		FSM_POP,
		FSM_PROC
	} fsm_t;

	typedef struct packed {
		logic imm;
		logic pop_rd;
		logic pop_fin;
		logic proc_start;
		logic proc_run;
		logic proc_fin;
	} cmd_t;

	typedef struct packed {
		logic free_empty;
		logic def_empty;
		logic proc_done;
	} sts_t;

endpackage

// ===== rtl/core/fdhp_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdhp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module fdhp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/core/fdhp_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdhp_ctrl
// Sequencer: decodes an accepted item and steps the datapath through a pop
// or a walk of the deferred queue.
// ----------------------------------------------------------------------------
module fdhp_ctrl (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [fdhp_pkg::OP_W-1:0]  op,
	input  fdhp_pkg::sts_t             sts,
	output logic                       busy,
	output fdhp_pkg::cmd_t             cmd
);

	fdhp_pkg::fsm_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fdhp_pkg::FSM_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			fdhp_pkg::FSM_IDLE: begin
				if (start) begin
					unique case (op)
						fdhp_pkg::OP_ACQUIRE: begin
							if (sts.free_empty) begin
								cmd.imm = 1'b1;
							end else begin
								cmd.pop_rd = 1'b1;
								state_d    = fdhp_pkg::FSM_POP;
							end
						end
						fdhp_pkg::OP_PROCESS: begin
							if (sts.def_empty) begin
								cmd.imm = 1'b1;
							end else begin
								cmd.proc_start = 1'b1;
								state_d        = fdhp_pkg::FSM_PROC;
							end
						end
						default: begin
							cmd.imm = 1'b1;
						end
					endcase
				end
			end
			fdhp_pkg::FSM_POP: begin
				cmd.pop_fin = 1'b1;
				state_d     = fdhp_pkg::FSM_IDLE;
			end
			fdhp_pkg::FSM_PROC: begin
				cmd.proc_run = 1'b1;
				if (sts.proc_done) begin
					cmd.proc_fin = 1'b1;
					state_d      = fdhp_pkg::FSM_IDLE;
				end
			end
			default: begin
				state_d = fdhp_pkg::FSM_IDLE;
			end
		endcase
	end

	assign busy = (state_q != fdhp_pkg::FSM_IDLE);

endmodule

// ===== rtl/core/fdhp_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdhp_dp
// Datapath: free stack and deferred queue memories, depth and mint counters,
// the fence walk with in-place compaction, and the result registers.
// ----------------------------------------------------------------------------
module fdhp_dp (
	input  logic                            clk,
	input  logic                            arst_n,
	input  fdhp_pkg::cmd_t                  cmd,
	input  logic [fdhp_pkg::OP_W-1:0]       op,
	input  logic                            has_handle,
	input  logic [fdhp_pkg::HANDLE_W-1:0]   handle,
	input  logic [fdhp_pkg::FENCE_W-1:0]    fence_value,
	input  logic [fdhp_pkg::LIMIT_W-1:0]    handle_limit,
	output fdhp_pkg::sts_t                  sts,
	output logic                            done,
	output logic                            granted,
	output logic [fdhp_pkg::HANDLE_W-1:0]   out_handle,
	output logic [fdhp_pkg::STATUS_W-1:0]   status,
	output logic [fdhp_pkg::FREED_W-1:0]    freed_count
);

	logic [fdhp_pkg::CNT_W-1:0]    free_depth_q, def_depth_q, minted_q;
	logic [fdhp_pkg::CNT_W-1:0]    rd_cnt_q, keep_q, freed_q;
	logic                          vld_s1;
	logic [fdhp_pkg::FENCE_W-1:0]  fence_q;

	logic                          done_q, granted_q;
	logic [fdhp_pkg::HANDLE_W-1:0] out_handle_q;
	logic [fdhp_pkg::STATUS_W-1:0] status_q;
	logic [fdhp_pkg::FREED_W-1:0]  freed_out_q;

	logic [fdhp_pkg::CMP_W-1:0]    lim_ext, max_ext, lim_eff;
	logic                          mint_ok, def_full, free_full;
	logic                          issue, ready_ent, push, keep_wr, rel_wr;
	logic [fdhp_pkg::CNT_W-1:0]    free_dec;
	logic [fdhp_pkg::HANDLE_W-1:0] free_rdata, rd_handle;
	logic [fdhp_pkg::DEF_W-1:0]    def_rdata, def_wdata;
	logic [fdhp_pkg::FENCE_W-1:0]  rd_fence;
	logic [fdhp_pkg::IDX_W-1:0]    def_waddr;
	logic                          res_load;
	logic                          res_granted;
	logic [fdhp_pkg::HANDLE_W-1:0] res_handle;
	logic [fdhp_pkg::STATUS_W-1:0] res_status;
	logic [fdhp_pkg::FREED_W-1:0]  res_freed;

	// Minting stops at the smaller of the register and the pool size.
	assign lim_ext   = fdhp_pkg::CMP_W'(handle_limit);
	assign max_ext   = fdhp_pkg::CMP_W'(fdhp_pkg::MAX_HANDLES);
	assign lim_eff   = (lim_ext < max_ext) ? lim_ext : max_ext;
	assign mint_ok   = (fdhp_pkg::CMP_W'(minted_q) < lim_eff);
	assign def_full  = (def_depth_q == fdhp_pkg::CNT_W'(fdhp_pkg::MAX_HANDLES));
	assign free_full = (free_depth_q == fdhp_pkg::CNT_W'(fdhp_pkg::MAX_HANDLES));
	assign free_dec  = free_depth_q - fdhp_pkg::CNT_W'(1);

	// The walk reads one entry per cycle and judges it in the next cycle. Kept
	// entries are written back at keep_q, which never passes the read point.
	assign issue     = cmd.proc_run && (rd_cnt_q < def_depth_q);
	assign rd_handle = def_rdata[fdhp_pkg::DEF_W-1 -: fdhp_pkg::HANDLE_W];
	assign rd_fence  = def_rdata[fdhp_pkg::FENCE_W-1:0];
	assign ready_ent = (rd_fence <= fence_q);
	assign push      = vld_s1 && ready_ent && !free_full;
	assign keep_wr   = vld_s1 && !ready_ent;
	assign rel_wr    = cmd.imm && (op == fdhp_pkg::OP_RELEASE) && has_handle && !def_full;

	assign def_waddr = keep_wr ? keep_q[fdhp_pkg::IDX_W-1:0]
	                           : def_depth_q[fdhp_pkg::IDX_W-1:0];
	assign def_wdata = keep_wr ? def_rdata : {handle, fence_value};

	fdhp_ram #(
		.WIDTH (fdhp_pkg::HANDLE_W),
		.DEPTH (fdhp_pkg::MAX_HANDLES)
	) u_free_ram (
		.clk   (clk),
		.we    (push),
		.waddr (free_depth_q[fdhp_pkg::IDX_W-1:0]),
		.wdata (rd_handle),
		.raddr (free_dec[fdhp_pkg::IDX_W-1:0]),
		.rdata (free_rdata)
	);

	fdhp_ram #(
		.WIDTH (fdhp_pkg::DEF_W),
		.DEPTH (fdhp_pkg::MAX_HANDLES)
	) u_def_ram (
		.clk   (clk),
		.we    (rel_wr || keep_wr),
		.waddr (def_waddr),
		.wdata (def_wdata),
		.raddr (rd_cnt_q[fdhp_pkg::IDX_W-1:0]),
		.rdata (def_rdata)
	);

	assign sts.free_empty = (free_depth_q == '0);
	assign sts.def_empty  = (def_depth_q == '0);
	assign sts.proc_done  = (rd_cnt_q == def_depth_q) && !vld_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_depth_q <= '0;
			def_depth_q  <= '0;
			minted_q     <= '0;
			rd_cnt_q     <= '0;
			keep_q       <= '0;
			freed_q      <= '0;
			vld_s1       <= 1'b0;
			done_q       <= 1'b0;
		end else begin
			if (push) begin
				free_depth_q <= free_depth_q + fdhp_pkg::CNT_W'(1);
			end else if (cmd.pop_fin) begin
				free_depth_q <= free_dec;
			end
			if (cmd.imm && (op == fdhp_pkg::OP_ACQUIRE) && mint_ok) begin
				minted_q <= minted_q + fdhp_pkg::CNT_W'(1);
			end
			if (rel_wr) begin
				def_depth_q <= def_depth_q + fdhp_pkg::CNT_W'(1);
			end else if (cmd.proc_fin) begin
				def_depth_q <= keep_q;
			end
			if (cmd.proc_start) begin
				rd_cnt_q <= '0;
				keep_q   <= '0;
				freed_q  <= '0;
			end else begin
				if (issue) begin
					rd_cnt_q <= rd_cnt_q + fdhp_pkg::CNT_W'(1);
				end
				if (keep_wr) begin
					keep_q <= keep_q + fdhp_pkg::CNT_W'(1);
				end
				if (push) begin
					freed_q <= freed_q + fdhp_pkg::CNT_W'(1);
				end
			end
			vld_s1 <= issue;
			done_q <= res_load;
		end
	end

	always_comb begin
		res_load    = cmd.imm || cmd.pop_fin || cmd.proc_fin;
		res_granted = 1'b0;
		res_handle  = '0;
		res_status  = fdhp_pkg::STAT_OK;
		res_freed   = '0;
		if (cmd.pop_fin) begin
			res_granted = 1'b1;
			res_handle  = free_rdata;
		end else if (cmd.proc_fin) begin
			res_freed = (fdhp_pkg::CMP_W'(freed_q) > fdhp_pkg::CMP_W'(fdhp_pkg::FREED_MAX))
			            ? fdhp_pkg::FREED_MAX : fdhp_pkg::FREED_W'(freed_q);
		end else if (cmd.imm) begin
			unique case (op)
				fdhp_pkg::OP_ACQUIRE: begin
					res_granted = mint_ok;
					res_handle  = mint_ok ? fdhp_pkg::HANDLE_W'(minted_q) : '0;
					res_status  = mint_ok ? fdhp_pkg::STAT_OK : fdhp_pkg::STAT_EXHAUSTED;
				end
				fdhp_pkg::OP_RELEASE: begin
					if (!has_handle) begin
						res_status = fdhp_pkg::STAT_NULL_REL;
					end else if (def_full) begin
						res_status = fdhp_pkg::STAT_DEF_FULL;
					end
				end
				default: begin
					res_status = fdhp_pkg::STAT_OK;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.proc_start) begin
			fence_q <= fence_value;
		end
		if (res_load) begin
			granted_q    <= res_granted;
			out_handle_q <= res_handle;
			status_q     <= res_status;
			freed_out_q  <= res_freed;
		end
	end

	assign done        = done_q;
	assign granted     = granted_q;
	assign out_handle  = out_handle_q;
	assign status      = status_q;
	assign freed_count = freed_out_q;

	a_free_depth_range: assert property (@(posedge clk) disable iff (!arst_n)
		free_depth_q <= fdhp_pkg::CNT_W'(fdhp_pkg::MAX_HANDLES))
		else $error("free stack depth beyond pool size");

	a_def_depth_range: assert property (@(posedge clk) disable iff (!arst_n)
		def_depth_q <= fdhp_pkg::CNT_W'(fdhp_pkg::MAX_HANDLES))
		else $error("deferred queue depth beyond pool size");

	a_keep_behind_read: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.proc_run |-> (keep_q <= rd_cnt_q))
		else $error("compaction write passed the read point");

	a_pop_completes: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pop_rd |=> (cmd.pop_fin && done_q == 1'b0))
		else $error("pop read not followed by pop completion");

	a_grant_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && granted_q) |-> (status_q == fdhp_pkg::STAT_OK && freed_out_q == '0))
		else $error("granted result carries a nonzero status or count");

endmodule

// ===== rtl/core/fence_deferred_handle_pool.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fence_deferred_handle_pool
// Handle allocator with a LIFO free stack and fence-gated deferred release.
// ----------------------------------------------------------------------------
// Usage:
//   An item (op, has_handle, handle, fence_value) is taken at a clock edge
//   where start is high and busy is low. Every item gives one result on
//   granted, out_handle, status and freed_count, shown for exactly one cycle
//   with done high. The receiver cannot stall; results are simply presented.
//   Sequence per item:
//     acquire that pops the free stack: busy in the pop state, which waits
//       for the registered stack read; result in the first idle cycle.
//     mint, failed acquire, release, unused op, process with an empty queue:
//       busy stays low, result in the cycle after the accept edge.
//     process with a nonempty queue: busy while the walk runs, result in
//       the first idle cycle; the walk reads one deferred-queue entry per
//       cycle and compares its 64-bit fence in the next cycle.
//   The handle_limit register sits at byte address 0 of the APB port. The
//   user must write it only while the block is idle; the block itself does
//   not enforce this. Reset clears all depths and the mint count and sets
//   handle_limit to 16; memory contents are not cleared.
// ----------------------------------------------------------------------------
module fence_deferred_handle_pool (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  logic [fdhp_pkg::OP_W-1:0]       op,
	input  logic                            has_handle,
	input  logic [fdhp_pkg::HANDLE_W-1:0]   handle,
	input  logic [fdhp_pkg::FENCE_W-1:0]    fence_value,
	output logic                            done,
	output logic                            granted,
	output logic [fdhp_pkg::HANDLE_W-1:0]   out_handle,
	output logic [fdhp_pkg::STATUS_W-1:0]   status,
	output logic [fdhp_pkg::FREED_W-1:0]    freed_count,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [fdhp_pkg::APB_AW-1:0]     paddr,
	input  logic [fdhp_pkg::APB_DW-1:0]     pwdata,
	output logic [fdhp_pkg::APB_DW-1:0]     prdata,
	output logic                            pready
);

	logic [fdhp_pkg::LIMIT_W-1:0] limit_q;
	logic                         reg_sel;
	fdhp_pkg::cmd_t               cmd;
	fdhp_pkg::sts_t               sts;

	assign pready  = 1'b1;
	assign reg_sel = (paddr[fdhp_pkg::APB_AW-1] == fdhp_pkg::REG_HANDLE_LIMIT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= fdhp_pkg::LIMIT_RESET;
		end else if (psel && penable && pwrite && pready && reg_sel) begin
			limit_q <= pwdata[fdhp_pkg::LIMIT_W-1:0];
		end
	end

	assign prdata = reg_sel ? fdhp_pkg::APB_DW'(limit_q) : '0;

	fdhp_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.op     (op),
		.sts    (sts),
		.busy   (busy),
		.cmd    (cmd)
	);

	fdhp_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.op           (op),
		.has_handle   (has_handle),
		.handle       (handle),
		.fence_value  (fence_value),
		.handle_limit (limit_q),
		.sts          (sts),
		.done         (done),
		.granted      (granted),
		.out_handle   (out_handle),
		.status       (status),
		.freed_count  (freed_count)
	);

endmodule
